// ----- rtl/fpba_pkg.sv -----
// shared constants and codes for the fit-policy block allocator
package fpba_pkg;

	localparam int unsigned NUM_BLOCKS_DEF = 16;
	localparam int unsigned SIZE_BITS_DEF  = 16;

	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned SEL_W   = 4;
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned RID_W   = 4;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned BIU_W   = 5;
	localparam int unsigned APB_AW  = 3;
	localparam int unsigned APB_DW  = 32;

	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd2;

	localparam logic [MODE_W-1:0] MODE_WORST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd2;

	localparam logic REG_FIT_MODE      = 1'b0;
	localparam logic REG_BLOCKS_IN_USE = 1'b1;

	localparam logic [MODE_W-1:0] FIT_MODE_RST      = MODE_FIRST;
	localparam logic [BIU_W-1:0]  BLOCKS_IN_USE_RST = 5'd16;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_COMMIT = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

endpackage

// ----- rtl/fit_policy_block_allocator_core.sv -----
// fit-policy block allocator: size table in a synchronous memory, one block compared per cycle
// sequence: a load, clear or unknown word goes from idle straight to done; an allocate word goes
// from idle to scan over blocks_in_use (saturated at NUM_BLOCKS) blocks, then to commit and done;
// done loads the response registers and waits there while the response side stalls
// one word in flight: req_stall is high from accept until the state returns to idle
// reset: all blocks free, fit_mode first fit, blocks_in_use 16; size and owner memories undefined
module fit_policy_block_allocator_core #(
	parameter int unsigned NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
	parameter int unsigned SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [fpba_pkg::FUNC_W-1:0]     func,
	input  logic [fpba_pkg::SEL_W-1:0]      block_select,
	input  logic [fpba_pkg::VALUE_W-1:0]    size_value,
	input  logic [fpba_pkg::RID_W-1:0]      request_id,
	// response channel
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic                            granted,
	output logic [fpba_pkg::SEL_W-1:0]      granted_block,
	output logic [fpba_pkg::VALUE_W-1:0]    leftover,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fpba_pkg::APB_AW-1:0]     paddr,
	input  logic [fpba_pkg::APB_DW-1:0]     pwdata,
	output logic [fpba_pkg::APB_DW-1:0]     prdata,
	output logic                            pready
);

	localparam int unsigned IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int unsigned CW0 = $clog2(NUM_BLOCKS + 1);
	localparam int unsigned LW = (CW0 > fpba_pkg::BIU_W) ? CW0 : fpba_pkg::BIU_W;

	// configuration registers
	logic [fpba_pkg::MODE_W-1:0] fit_mode_q;
	logic [fpba_pkg::BIU_W-1:0]  blocks_in_use_q;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q      <= fpba_pkg::FIT_MODE_RST;
			blocks_in_use_q <= fpba_pkg::BLOCKS_IN_USE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				fpba_pkg::REG_FIT_MODE:      fit_mode_q <= pwdata[fpba_pkg::MODE_W-1:0];
				fpba_pkg::REG_BLOCKS_IN_USE: blocks_in_use_q <= pwdata[fpba_pkg::BIU_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			fpba_pkg::REG_FIT_MODE:      prdata = fpba_pkg::APB_DW'(fit_mode_q);
			fpba_pkg::REG_BLOCKS_IN_USE: prdata = fpba_pkg::APB_DW'(blocks_in_use_q);
			default: prdata = '0;
		endcase
	end

	// control and working registers
	fpba_pkg::state_t state_q;
	logic                       req_acc;
	logic                       rsp_free;
	logic [SIZE_BITS-1:0]       req_size;
	logic [SIZE_BITS-1:0]       size_q;
	logic [fpba_pkg::RID_W-1:0] rid_q;
	logic [LW-1:0]              limit_q;
	logic [LW-1:0]              idx_q;
	logic                       issue;
	logic                       rd_valid_s1;
	logic [IW-1:0]              rd_idx_s1;
	logic [SIZE_BITS-1:0]       rd_size_s1;
	logic                       found_q;
	logic [IW-1:0]              best_idx_q;
	logic [SIZE_BITS-1:0]       best_size_q;
	logic [NUM_BLOCKS-1:0]      taken_q;
	logic                       fits;
	logic                       better;
	logic                       res_granted_q;
	logic [fpba_pkg::SEL_W-1:0] res_block_q;
	logic [fpba_pkg::VALUE_W-1:0] res_left_q;
	logic                       rsp_valid_q;
	logic                       rsp_granted_q;
	logic [fpba_pkg::SEL_W-1:0] rsp_block_q;
	logic [fpba_pkg::VALUE_W-1:0] rsp_left_q;
	logic                       load_we;
	logic [LW-1:0]              biu_ext;

	// block table memories
	logic [SIZE_BITS-1:0]       size_mem [NUM_BLOCKS];
	logic [fpba_pkg::RID_W-1:0] owner_mem [NUM_BLOCKS];

	assign req_stall = (state_q != fpba_pkg::ST_IDLE);
	assign req_acc   = req_valid & ~req_stall;
	assign rsp_free  = ~rsp_valid_q | ~rsp_stall;
	assign req_size  = SIZE_BITS'(size_value);
	assign load_we   = req_acc && (func == fpba_pkg::FUNC_LOAD)
		&& (LW'(block_select) < LW'(NUM_BLOCKS));
	assign issue     = (state_q == fpba_pkg::ST_SCAN) && (idx_q < limit_q);
	assign biu_ext   = LW'(blocks_in_use_q);

	always_ff @(posedge clk) begin
		if (load_we) begin
			size_mem[IW'(block_select)] <= req_size;
		end
		rd_size_s1 <= size_mem[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == fpba_pkg::ST_COMMIT && found_q) begin
			owner_mem[best_idx_q] <= rid_q;
		end
	end

	// candidate test for the word read last cycle
	always_comb begin
		fits   = rd_valid_s1 && !taken_q[rd_idx_s1] && (rd_size_s1 >= size_q);
		better = 1'b0;
		if (fits) begin
			if (!found_q) begin
				better = 1'b1;
			end else begin
				case (fit_mode_q)
					fpba_pkg::MODE_BEST:  better = rd_size_s1 < best_size_q;
					fpba_pkg::MODE_WORST: better = rd_size_s1 > best_size_q;
					default:              better = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpba_pkg::ST_IDLE;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			taken_q     <= '0;
			rsp_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			rd_valid_s1 <= issue;
			if (issue) begin
				idx_q <= idx_q + LW'(1);
			end
			if (better) begin
				found_q <= 1'b1;
			end
			if (state_q == fpba_pkg::ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				fpba_pkg::ST_IDLE: begin
					if (req_acc) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						if (func == fpba_pkg::FUNC_CLEAR) begin
							taken_q <= '0;
						end
						state_q <= (func == fpba_pkg::FUNC_ALLOC) ? fpba_pkg::ST_SCAN
							: fpba_pkg::ST_DONE;
					end
				end
				fpba_pkg::ST_SCAN: begin
					if (!issue && !rd_valid_s1) begin
						state_q <= fpba_pkg::ST_COMMIT;
					end
				end
				fpba_pkg::ST_COMMIT: begin
					if (found_q) begin
						taken_q[best_idx_q] <= 1'b1;
					end
					state_q <= fpba_pkg::ST_DONE;
				end
				fpba_pkg::ST_DONE: begin
					if (rsp_free) begin
						state_q <= fpba_pkg::ST_IDLE;
					end
				end
				default: state_q <= fpba_pkg::ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[IW-1:0];
		if (better) begin
			best_idx_q  <= rd_idx_s1;
			best_size_q <= rd_size_s1;
		end
		if (req_acc) begin
			size_q        <= req_size;
			rid_q         <= request_id;
			limit_q       <= (biu_ext > LW'(NUM_BLOCKS)) ? LW'(NUM_BLOCKS) : biu_ext;
			res_granted_q <= 1'b0;
			res_block_q   <= '0;
			res_left_q    <= '0;
		end
		if (state_q == fpba_pkg::ST_COMMIT && found_q) begin
			res_granted_q <= 1'b1;
			res_block_q   <= fpba_pkg::SEL_W'(best_idx_q);
			res_left_q    <= fpba_pkg::VALUE_W'(best_size_q - size_q);
		end
		if (state_q == fpba_pkg::ST_DONE && rsp_free) begin
			rsp_granted_q <= res_granted_q;
			rsp_block_q   <= res_block_q;
			rsp_left_q    <= res_left_q;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign granted       = rsp_granted_q;
	assign granted_block = rsp_block_q;
	assign leftover      = rsp_left_q;

endmodule

// ----- tb/grant_scoreboard_pkg.sv -----
// allocation predictor and result scoreboard for the fit-policy block allocator testbench
package grant_scoreboard_pkg;

	import fpba_pkg::*;

	// codes the design package leaves unnamed
	localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
	localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;

	typedef struct {
		logic               granted;
		logic [SEL_W-1:0]   blk;
		logic [VALUE_W-1:0] left;
	} grant_t;

	class grant_scoreboard;
		logic [VALUE_W-1:0] size_tab [NUM_BLOCKS_DEF];
		logic [RID_W-1:0]   owner    [NUM_BLOCKS_DEF];
		bit [NUM_BLOCKS_DEF-1:0] taken;
		logic [MODE_W-1:0]  mode;
		logic [BIU_W-1:0]   in_use;
		grant_t             due_grants [$];
		int                 mismatches;

		function new();
			taken      = '0;
			mode       = FIT_MODE_RST;
			in_use     = BLOCKS_IN_USE_RST;
			mismatches = 0;
			foreach (size_tab[k]) begin
				size_tab[k] = '0;
				owner[k]    = '0;
			end
		endfunction

		function int outstanding();
			return due_grants.size();
		endfunction

		function void set_reg(logic idx, logic [APB_DW-1:0] v);
			if (idx == REG_FIT_MODE) begin
				mode = v[MODE_W-1:0];
			end else begin
				in_use = v[BIU_W-1:0];
			end
		endfunction

		task report(string msg);
			if (mismatches < 200) begin
				$display("[%0t] mismatch: %s", $realtime, msg);
			end
			mismatches++;
		endtask

		// works out the grant for an accepted word and updates the block table
		function void note_word(logic [FUNC_W-1:0] f, logic [SEL_W-1:0] sel,
				logic [VALUE_W-1:0] sz, logic [RID_W-1:0] rid);
			grant_t g;
			int     lim;
			int     pick;
			bit     found;
			g     = '{1'b0, '0, '0};
			found = 1'b0;
			pick  = 0;
			case (f)
				FUNC_LOAD: begin
					size_tab[sel] = sz;
				end
				FUNC_CLEAR: begin
					taken = '0;
				end
				FUNC_ALLOC: begin
					lim = (in_use > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : in_use;
					for (int k = 0; k < lim; k++) begin
						if (taken[k] || size_tab[k] < sz) continue;
						if (!found) begin
							found = 1'b1;
							pick  = k;
							// first fit, and the unused mode code, stop at the first candidate
							if (mode != MODE_WORST && mode != MODE_BEST) break;
						end else if (mode == MODE_BEST) begin
							if (size_tab[k] < size_tab[pick]) pick = k;
						end else if (mode == MODE_WORST) begin
							if (size_tab[k] > size_tab[pick]) pick = k;
						end
					end
					if (found) begin
						taken[pick] = 1'b1;
						owner[pick] = rid;
						g.granted   = 1'b1;
						g.blk       = SEL_W'(pick);
						g.left      = size_tab[pick] - sz;
					end
				end
				default: ;
			endcase
			due_grants.push_back(g);
		endfunction

		task check_word(logic g, logic [SEL_W-1:0] b, logic [VALUE_W-1:0] l);
			grant_t want;
			if (due_grants.size() == 0) begin
				report($sformatf("result with no word outstanding: granted %0d block %0d leftover %0d",
					g, b, l));
				return;
			end
			want = due_grants.pop_front();
			if (g !== want.granted)
				report($sformatf("granted %0d, predicted %0d", g, want.granted));
			if (b !== want.blk)
				report($sformatf("granted_block %0d, predicted %0d", b, want.blk));
			if (l !== want.left)
				report($sformatf("leftover %0d, predicted %0d", l, want.left));
		endtask
	endclass

endpackage

// ----- tb/testbench.sv -----
// top-level testbench: directed and random words against the fit-policy block allocator
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import fpba_pkg::*;
	import grant_scoreboard_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES      = 12;
	localparam int PHASE_WORDS = 112;

	localparam logic [VALUE_W-1:0] DIR_SIZES [16] = '{
		16'd0, 16'hFFFF, 16'd40, 16'd40, 16'd1, 16'd300, 16'd40, 16'h8000,
		16'h7FFF, 16'd12, 16'd40, 16'hFFFE, 16'd2, 16'd1000, 16'd40, 16'h5555
	};

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               req_valid    = 1'b0;
	logic               req_stall;
	logic [FUNC_W-1:0]  func         = FUNC_LOAD;
	logic [SEL_W-1:0]   block_select = '0;
	logic [VALUE_W-1:0] size_value   = '0;
	logic [RID_W-1:0]   request_id   = '0;
	logic               rsp_valid;
	logic               rsp_stall    = 1'b0;
	logic               granted;
	logic [SEL_W-1:0]   granted_block;
	logic [VALUE_W-1:0] leftover;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [APB_AW-1:0]  paddr        = '0;
	logic [APB_DW-1:0]  pwdata       = '0;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	grant_scoreboard sb = new();

	int send_idle_pct = 20;
	int recv_idle_pct = 69;
	bit hold_req      = 1'b0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	fit_policy_block_allocator_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.func         (func),
		.block_select (block_select),
		.size_value   (size_value),
		.request_id   (request_id),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.granted      (granted),
		.granted_block(granted_block),
		.leftover     (leftover),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: random stalls, or one long hold-off when asked for
	always @(negedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_word(granted, granted_block, leftover);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offers one word, holds it until taken; valid stays high for a following word
	task automatic send_word(input logic [FUNC_W-1:0] f, input logic [SEL_W-1:0] sel,
			input logic [VALUE_W-1:0] sz, input logic [RID_W-1:0] rid);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid    <= 1'b1;
		func         <= f;
		block_select <= sel;
		size_value   <= sz;
		request_id   <= rid;
		do @(posedge clk); while (req_stall);
		sb.note_word(f, sel, sz, rid);
	endtask

	task automatic wait_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	// register write then read-back; only called with the block idle
	task automatic program_reg(input logic idx, input logic [APB_DW-1:0] val);
		logic [APB_DW-1:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		if (got !== val)
			sb.report($sformatf("register %0d reads %0h, written %0h", idx, got, val));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : stimulus
		logic [MODE_W-1:0]  phase_mode [6];
		int                 phase_in_use [6];
		logic [FUNC_W-1:0]  f;
		logic [VALUE_W-1:0] sz;
		int                 n;
		int                 r;
		bit                 narrow;
		phase_mode   = '{MODE_WORST, MODE_BEST, MODE_FIRST, MODE_UNKNOWN, MODE_BEST, MODE_WORST};
		phase_in_use = '{16, 1, 31, 0, 16, 2};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every block gets a size before anything is allocated
		for (int k = 0; k < 16; k++)
			send_word(FUNC_LOAD, SEL_W'(k), DIR_SIZES[k], RID_W'(k));
		send_word(FUNC_ALLOC, 4'd0, 16'd0, 4'd0);
		send_word(FUNC_ALLOC, 4'd15, 16'hFFFF, 4'd15);
		send_word(FUNC_ALLOC, 4'd0, 16'hFFFF, 4'd5);
		send_word(FUNC_UNKNOWN, 4'hF, 16'hFFFF, 4'hF);
		send_word(FUNC_CLEAR, 4'd7, 16'h1234, 4'd9);
		wait_results();
		program_reg(REG_FIT_MODE, 32'(MODE_WORST));
		send_word(FUNC_ALLOC, 4'd0, 16'd40, 4'd3);
		wait_results();
		program_reg(REG_FIT_MODE, 32'(MODE_BEST));
		send_word(FUNC_ALLOC, 4'd0, 16'd40, 4'd4);
		send_word(FUNC_ALLOC, 4'd0, 16'd40, 4'd6);
		wait_results();
		program_reg(REG_FIT_MODE, 32'(MODE_UNKNOWN));
		program_reg(REG_BLOCKS_IN_USE, 32'd0);
		send_word(FUNC_ALLOC, 4'd0, 16'd0, 4'd1);
		wait_results();
		program_reg(REG_BLOCKS_IN_USE, 32'd31);
		send_word(FUNC_ALLOC, 4'd0, 16'hFFFE, 4'd2);
		send_word(FUNC_CLEAR, 4'd0, 16'd0, 4'd0);

		for (int p = 0; p < PHASES; p++) begin
			wait_results();
			if (p < 6) begin
				program_reg(REG_FIT_MODE, 32'(phase_mode[p]));
				program_reg(REG_BLOCKS_IN_USE, 32'(phase_in_use[p]));
			end else begin
				program_reg(REG_FIT_MODE, 32'($urandom_range(3)));
				program_reg(REG_BLOCKS_IN_USE, 32'($urandom_range(1, 17)));
			end
			send_idle_pct = (p < 4) ? 20 : (p < 8) ? 69 : 0;
			recv_idle_pct = (p < 4) ? 69 : (p < 8) ? 20 : 0;
			// narrow phases keep sizes small so equal-size ties come up often
			narrow = p[0];
			n = 0;
			while (n < PHASE_WORDS) begin
				r = $urandom_range(99);
				if (r < 70) f = FUNC_ALLOC;
				else if (r < 86) f = FUNC_LOAD;
				else if (r < 94) f = FUNC_CLEAR;
				else f = FUNC_UNKNOWN;
				sz = narrow ? VALUE_W'($urandom_range(24)) : VALUE_W'($urandom_range(16'hFFFF));
				send_word(f, SEL_W'($urandom_range(15)), sz, RID_W'($urandom_range(15)));
				if (f != FUNC_UNKNOWN) n++;
				// fill the block up behind a long result stall
				if (p == 0 && n == 40) hold_req = 1'b1;
				if (p == 5 && n == 60) wait_results();
			end
		end

		wait_results();
		repeat (40) @(posedge clk);
		if (sb.outstanding() != 0)
			sb.report($sformatf("%0d results never arrived", sb.outstanding()));
		if (sb.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/fpba_pkg.sv
rtl/fit_policy_block_allocator_core.sv
tb/grant_scoreboard_pkg.sv
tb/testbench.sv
